// ===== rtl/core/sfir_pkg.sv =====
// shared constants, types and control bundle for the symmetric fir filter
package sfir_pkg;

  localparam int TAP_COUNT    = 63;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEFF_WIDTH  = 16;
  localparam int MODE_W       = 2;
  localparam int INDEX_W      = 5;

  localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_we;
    logic load_sum;
    logic step;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sfir_cell.sv =====
// one folded tap cell: front and back delay samples, its coefficient, and a pair-sum shift stage
module sfir_cell #(
  parameter int IDX = 0,
  parameter int SW  = sfir_pkg::SAMPLE_WIDTH,
  parameter int CW  = sfir_pkg::COEFF_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfir_pkg::cell_ctl_t           ctl,
  input  logic [sfir_pkg::INDEX_W-1:0]  coef_index,
  input  logic signed [CW-1:0]          coef_value,
  input  logic signed [SW-1:0]          f_in,
  output logic signed [SW-1:0]          f_out,
  input  logic signed [SW-1:0]          b_in,
  output logic signed [SW-1:0]          b_out,
  input  logic signed [SW:0]            p_in,
  output logic signed [SW:0]            p_out,
  input  logic signed [CW-1:0]          q_in,
  output logic signed [CW-1:0]          q_out
);

  localparam logic [7:0] IDX_L = 8'(IDX);

  logic signed [SW-1:0] f;
  logic signed [SW-1:0] b;
  logic signed [CW-1:0] coef;
  logic signed [SW:0]   p;
  logic signed [CW-1:0] q;
  logic                 hit;

  assign hit = ({{(8 - sfir_pkg::INDEX_W){1'b0}}, coef_index} == IDX_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      f    <= '0;
      b    <= '0;
      coef <= '0;
    end else begin
      if (ctl.clear) begin
        f <= '0;
        b <= '0;
      end else if (ctl.shift) begin
        f <= f_in;
        b <= b_in;
      end
      if (ctl.coef_we && hit) begin
        coef <= coef_value;
      end
    end
  end

  // pair sums are loaded in parallel, then stream toward the mac
  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      p <= (SW+1)'(f) + (SW+1)'(b);
      q <= coef;
    end else if (ctl.step) begin
      p <= p_in;
      q <= q_in;
    end
  end

  assign f_out = f;
  assign b_out = b;
  assign p_out = p;
  assign q_out = q;

endmodule

// ===== rtl/core/symmetric_fir_filter_unit.sv =====
// top level: sequencer, folded cell row, multiply-accumulate and rounding output stage
//
// Odd-length linear-phase FIR. One input channel (in_valid / in_stall) carries
// a mode, a sample, a coefficient index and a coefficient value per beat.
// Mode 0 pushes a sample and yields one output beat (sample_out, saturated);
// mode 1 writes one half-table coefficient (centre tap last); mode 2 zeroes
// the history; mode 3 is dropped. Load, clear and unused beats are done at
// acceptance and leave in_stall low. A filter beat works on the HALF =
// (TAP_COUNT+1)/2 pair sums: it loads them into the cell row, shifts them
// one per cycle through the single multiplier, drains the accumulator, then
// rounds into the output register. in_stall stays high while a beat is at
// work. A waiting result does not block acceptance of the next beat; a new
// result waits in the round stage while out_stall holds the old one.
// Reset clears the history and the coefficient store (output is silent) and
// empties the output register.
module symmetric_fir_filter_unit #(
  parameter int TAP_COUNT    = sfir_pkg::TAP_COUNT,
  parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH,
  parameter int COEFF_WIDTH  = sfir_pkg::COEFF_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sfir_pkg::MODE_W-1:0]        mode,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
  input  logic [sfir_pkg::INDEX_W-1:0]       coeff_index,
  input  logic signed [COEFF_WIDTH-1:0]      coeff_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
  output logic                               saturated
);

  localparam int HALF   = (TAP_COUNT + 1) / 2;
  localparam int CNT_W  = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int PW     = SAMPLE_WIDTH + 1 + COEFF_WIDTH;
  localparam int ACC_X  = PW + CNT_W;
  localparam int ACC_W  = (ACC_X > 64) ? 64 : ACC_X;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HALF - 1);

  sfir_pkg::state_t    state;
  sfir_pkg::state_t    state_next;
  sfir_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0]        cnt;
  logic                    accept;
  logic                    can_write;
  logic signed [PW-1:0]    prod;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shf;
  logic                    over;
  logic signed [SAMPLE_WIDTH-1:0] res;

  logic signed [SAMPLE_WIDTH-1:0] f_out [HALF];
  logic signed [SAMPLE_WIDTH-1:0] b_out [HALF];
  logic signed [SAMPLE_WIDTH:0]   p_out [HALF];
  logic signed [COEFF_WIDTH-1:0]  q_out [HALF];

  assign in_stall  = (state != sfir_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_write = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfir_pkg::S_IDLE: begin
        if (accept && mode == sfir_pkg::MODE_FILTER) state_next = sfir_pkg::S_LOAD;
      end
      sfir_pkg::S_LOAD:  state_next = sfir_pkg::S_MAC;
      sfir_pkg::S_MAC: begin
        if (cnt == CNT_LAST) state_next = sfir_pkg::S_DRAIN;
      end
      sfir_pkg::S_DRAIN: state_next = sfir_pkg::S_DONE;
      sfir_pkg::S_DONE: begin
        if (can_write) state_next = sfir_pkg::S_IDLE;
      end
      default: state_next = sfir_pkg::S_IDLE;
    endcase
  end

  // commands to the cell row
  always_comb begin
    ctl          = '0;
    ctl.shift    = accept && (mode == sfir_pkg::MODE_FILTER);
    ctl.clear    = accept && (mode == sfir_pkg::MODE_CLEAR);
    ctl.coef_we  = accept && (mode == sfir_pkg::MODE_LOAD);
    ctl.load_sum = (state == sfir_pkg::S_LOAD);
    ctl.step     = (state == sfir_pkg::S_MAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfir_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == sfir_pkg::S_MAC) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < HALF; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] f_src;
      logic signed [SAMPLE_WIDTH-1:0] b_src;
      logic signed [SAMPLE_WIDTH:0]   p_src;
      logic signed [COEFF_WIDTH-1:0]  q_src;

      if (i == 0) begin : g_first
        assign f_src = sample_in;
      end else begin : g_mid
        assign f_src = f_out[i-1];
      end

      // back half is fed by the centre sample; the centre back slot holds zero
      if (i == HALF - 1) begin : g_centre
        assign b_src = b_out[i];
        assign p_src = '0;
        assign q_src = '0;
      end else begin : g_pair
        if (i == HALF - 2) begin : g_turn
          assign b_src = f_out[HALF-1];
        end else begin : g_back
          assign b_src = b_out[i+1];
        end
        assign p_src = p_out[i+1];
        assign q_src = q_out[i+1];
      end

      sfir_cell #(
        .IDX (i),
        .SW  (SAMPLE_WIDTH),
        .CW  (COEFF_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .coef_index (coeff_index),
        .coef_value (coeff_value),
        .f_in       (f_src),
        .f_out      (f_out[i]),
        .b_in       (b_src),
        .b_out      (b_out[i]),
        .p_in       (p_src),
        .p_out      (p_out[i]),
        .q_in       (q_src),
        .q_out      (q_out[i])
      );
    end
  endgenerate

  // multiply then accumulate, one registered stage each
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == sfir_pkg::S_MAC);
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(p_out[0] * q_out[0]);
    if (state == sfir_pkg::S_LOAD) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd  = acc + (ACC_W'(1) <<< (COEFF_WIDTH - 2));
    shf  = rnd >>> (COEFF_WIDTH - 1);
    over = !((&shf[ACC_W-1:SAMPLE_WIDTH-1]) || !(|shf[ACC_W-1:SAMPLE_WIDTH-1]));
    if (!over) begin
      res = shf[SAMPLE_WIDTH-1:0];
    end else if (shf[ACC_W-1]) begin
      res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == sfir_pkg::S_DONE && can_write) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sfir_pkg::S_DONE && can_write) begin
      sample_out <= res;
      saturated  <= over;
    end
  end

endmodule
